// ===== rtl/hamenc_pkg.sv =====
// Shared types and the SECDED(16,11) encode function of the byte stream encoder.
// Used by the front, the group queue and the back; depends on nothing else.
`default_nettype none

package hamenc_pkg;

   localparam int unsigned GroupBits = 11;
   localparam int unsigned WordBits  = 16;

   // One data group on its way from the front to the back.
   typedef struct packed {
      logic [GroupBits-1:0] group;
      logic                 last;
   } hamenc_grp_type;

   // Maps an 11-bit group to a 16-bit extended Hamming codeword.
   // Code position p is codeword bit 15-p.
   function automatic logic [WordBits-1:0] hamenc_encode(logic [GroupBits-1:0] grp);
      logic [WordBits-1:0] pos;
      logic [WordBits-1:0] word;
      pos      = '0;
      pos[3]   = grp[10];
      pos[5]   = grp[9];
      pos[6]   = grp[8];
      pos[7]   = grp[7];
      pos[9]   = grp[6];
      pos[10]  = grp[5];
      pos[11]  = grp[4];
      pos[12]  = grp[3];
      pos[13]  = grp[2];
      pos[14]  = grp[1];
      pos[15]  = grp[0];
      pos[1]   = pos[3] ^ pos[5] ^ pos[7] ^ pos[9] ^ pos[11] ^ pos[13] ^ pos[15];
      pos[2]   = pos[3] ^ pos[6] ^ pos[7] ^ pos[10] ^ pos[11] ^ pos[14] ^ pos[15];
      pos[4]   = pos[5] ^ pos[6] ^ pos[7] ^ pos[12] ^ pos[13] ^ pos[14] ^ pos[15];
      pos[8]   = pos[9] ^ pos[10] ^ pos[11] ^ pos[12] ^ pos[13] ^ pos[14] ^ pos[15];
      pos[0]   = ^pos[WordBits-1:1];
      for (int p = 0; p < WordBits; p++) begin
         word[WordBits-1-p] = pos[p];
      end
      return word;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/hamenc_req_if.sv =====
// Input channel of the encoder: one stream byte per word with valid/ready.
// Stand-alone interface; no dependencies.
`default_nettype none

interface hamenc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

`default_nettype wire

// ===== rtl/hamenc_rsp_if.sv =====
// Result channel of the encoder: one 16-bit codeword per word with valid/ready.
// Stand-alone interface; no dependencies.
`default_nettype none

interface hamenc_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] codeword;
   logic        last_word;

   modport source (output valid, output codeword, output last_word, input ready);
   modport sink   (input valid, input codeword, input last_word, output ready);
endinterface

`default_nettype wire

// ===== rtl/hamenc_front.sv =====
// Front of the encoder: packs bytes into 11-bit groups, pads on the last byte,
// and hands groups to the queue one per cycle while it has room. Depends on hamenc_pkg.
`default_nettype none

module hamenc_front
   import hamenc_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           in_valid,
   output logic                in_ready,
   input  wire logic [7:0]     in_byte,
   input  wire logic           in_last,
   output logic                q_push,
   output hamenc_grp_type      q_data,
   input  wire logic           q_ready
);

   typedef struct packed {
      logic                 done;
      logic [GroupBits-1:0] group;
      logic [GroupBits-1:0] bits;
      logic [3:0]           cnt;
   } push_type;

   // Appends one byte to the pending bits; reports a completed group.
   function automatic push_type push_byte(logic [GroupBits-1:0] bits, logic [3:0] cnt,
                                          logic [7:0] b);
      logic [18:0] acc;
      logic [4:0]  n;
      logic [2:0]  sh;
      push_type    r;
      acc = {bits, b};
      n   = {1'b0, cnt} + 5'd8;
      if (n >= 5'(GroupBits)) begin
         sh      = 3'(n - 5'(GroupBits));
         r.done  = 1'b1;
         r.group = 11'(acc >> sh);
         r.bits  = 11'(acc & ((19'd1 << sh) - 19'd1));
         r.cnt   = 4'(n - 5'(GroupBits));
      end else begin
         r.done  = 1'b0;
         r.group = '0;
         r.bits  = acc[GroupBits-1:0];
         r.cnt   = n[3:0];
      end
      return r;
   endfunction

   logic [GroupBits-1:0] pend_bits_ff, pend_bits_in;
   logic [3:0]           pend_cnt_ff, pend_cnt_in;
   logic                 odd_ff, odd_in;
   hamenc_grp_type       slot_ff [3];
   hamenc_grp_type       slot_in [3];
   logic [2:0]           slot_vld_ff, slot_vld_in;

   push_type             p1, p2;
   logic                 odd_next;
   logic                 pad_vld, flush_vld;
   logic [GroupBits-1:0] flush_grp;
   hamenc_grp_type       ent [3];
   logic [2:0]           ent_vld;
   hamenc_grp_type       shifted [3];
   logic [2:0]           shifted_vld;
   logic                 accept;
   logic [1:0]           fill;

   always_comb begin
      odd_next  = ~odd_ff;
      p1        = push_byte(pend_bits_ff, pend_cnt_ff, in_byte);
      p2        = push_byte(p1.bits, p1.cnt, 8'h00);
      pad_vld   = in_last & odd_next & p2.done;
      if (in_last & odd_next) begin
         flush_vld = p2.cnt != 4'd0;
         flush_grp = 11'(p2.bits << (4'(GroupBits) - p2.cnt));
      end else begin
         flush_vld = in_last & (p1.cnt != 4'd0);
         flush_grp = 11'(p1.bits << (4'(GroupBits) - p1.cnt));
      end

      ent[0]     = '{group: p1.group, last: in_last & ~pad_vld & ~flush_vld};
      ent[1]     = '{group: p2.group, last: in_last & ~flush_vld};
      ent[2]     = '{group: flush_grp, last: in_last};
      ent_vld    = {flush_vld, pad_vld, p1.done};
   end

   // The head slot drains into the queue; a new byte is taken once the
   // slots are empty after this cycle's drain.
   assign q_push = slot_vld_ff[0] & q_ready;
   assign q_data = slot_ff[0];

   always_comb begin
      if (q_push) begin
         shifted[0]  = slot_ff[1];
         shifted[1]  = slot_ff[2];
         shifted[2]  = slot_ff[2];
         shifted_vld = {1'b0, slot_vld_ff[2:1]};
      end else begin
         shifted     = slot_ff;
         shifted_vld = slot_vld_ff;
      end
   end

   assign in_ready = ~shifted_vld[0];
   assign accept   = in_valid & in_ready;

   always_comb begin
      slot_in      = shifted;
      slot_vld_in  = shifted_vld;
      pend_bits_in = pend_bits_ff;
      pend_cnt_in  = pend_cnt_ff;
      odd_in       = odd_ff;
      fill         = 2'd0;
      if (accept) begin
         slot_vld_in = '0;
         for (int i = 0; i < 3; i++) begin
            if (ent_vld[i]) begin
               slot_in[fill]     = ent[i];
               slot_vld_in[fill] = 1'b1;
               fill              = fill + 2'd1;
            end
         end
         if (in_last) begin
            pend_bits_in = '0;
            pend_cnt_in  = '0;
            odd_in       = 1'b0;
         end else begin
            pend_bits_in = p1.bits;
            pend_cnt_in  = p1.cnt;
            odd_in       = odd_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_bits_ff <= '0;
         pend_cnt_ff  <= '0;
         odd_ff       <= 1'b0;
         slot_vld_ff  <= '0;
      end else begin
         pend_bits_ff <= pend_bits_in;
         pend_cnt_ff  <= pend_cnt_in;
         odd_ff       <= odd_in;
         slot_vld_ff  <= slot_vld_in;
      end
      slot_ff <= slot_in;
   end

endmodule

`default_nettype wire

// ===== rtl/hamenc_fifo.sv =====
// Short group queue that decouples the encoder front from the back.
// Depends on hamenc_pkg for the entry type.
`default_nettype none

module hamenc_fifo
   import hamenc_pkg::*;
#(
   parameter int unsigned Depth = 4
) (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      wr_en,
   input  hamenc_grp_type wr_data,
   output logic           wr_ready,
   output logic           rd_valid,
   output hamenc_grp_type rd_data,
   input  wire logic      rd_en
);

   localparam int unsigned IdxW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int unsigned CntW = $clog2(Depth + 1);

   hamenc_grp_type  mem_ff [Depth];
   logic [IdxW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [IdxW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            do_wr, do_rd;

   assign wr_ready = count_ff != CntW'(Depth);
   assign rd_valid = count_ff != '0;
   assign rd_data  = mem_ff[rd_ptr_ff];
   assign do_wr    = wr_en & wr_ready;
   assign do_rd    = rd_en & rd_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == IdxW'(Depth - 1)) ? '0 : wr_ptr_ff + IdxW'(1);
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == IdxW'(Depth - 1)) ? '0 : rd_ptr_ff + IdxW'(1);
      end
      if (do_wr & ~do_rd) begin
         count_in = count_ff + CntW'(1);
      end else if (do_rd & ~do_wr) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/hamenc_back.sv =====
// Back of the encoder: takes groups from the queue, encodes them and holds
// the codeword in the output register. Depends on hamenc_pkg.
`default_nettype none

module hamenc_back
   import hamenc_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          q_valid,
   input  hamenc_grp_type     q_data,
   output logic               q_pop,
   output logic               out_valid,
   input  wire logic          out_ready,
   output logic [WordBits-1:0] out_word,
   output logic               out_last
);

   logic                out_vld_ff, out_vld_in;
   logic [WordBits-1:0] word_ff;
   logic                last_ff;

   assign q_pop      = q_valid & (~out_vld_ff | out_ready);
   assign out_vld_in = q_pop | (out_vld_ff & ~out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= out_vld_in;
      end
      if (q_pop) begin
         word_ff <= hamenc_encode(q_data.group);
         last_ff <= q_data.last;
      end
   end

   assign out_valid = out_vld_ff;
   assign out_word  = word_ff;
   assign out_last  = last_ff;

endmodule

`default_nettype wire

// ===== rtl/byte_stream_hamming_16_11_encoder_core.sv =====
// Byte stream to extended Hamming SECDED(16,11) encoder, top level.
// A group completed by a byte passes the front's slot registers, the queue and the output register.
// Throughput: one byte per cycle while the result side keeps up; a non-final byte completes at most one group.
// A final byte may yield up to three words; the front holds off new bytes until they have left its slots.
// Reset is synchronous and active high; it empties the queue and drops any partial group.
// Depends on hamenc_pkg, hamenc_req_if, hamenc_rsp_if, hamenc_front, hamenc_fifo, hamenc_back.
`default_nettype none

module byte_stream_hamming_16_11_encoder_core
   import hamenc_pkg::*;
#(
   // Number of groups the queue between front and back can hold.
   parameter int unsigned QueueDepth = 4
) (
   input  wire logic    clock,
   input  wire logic    reset,
   hamenc_req_if.sink   req_ch,
   hamenc_rsp_if.source rsp_ch
);

   // The front keeps the pending bits of the current stream and the byte
   // count parity. Each accepted byte is split into the groups it produces:
   // the group it completes, on a final byte the group completed by the zero
   // pad byte when the stream has an odd byte count, and the zero-padded
   // flush of the remaining bits. Those groups wait in a small slot stack
   // and move into the queue one per cycle while it has room.
   hamenc_grp_type front_data;
   logic           front_push;
   logic           queue_ready;

   // The queue lets the front keep taking bytes while the result side stalls.
   hamenc_grp_type queue_data;
   logic           queue_valid;
   logic           queue_pop;

   hamenc_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_ch.valid),
      .in_ready (req_ch.ready),
      .in_byte  (req_ch.data_byte),
      .in_last  (req_ch.last_byte),
      .q_push   (front_push),
      .q_data   (front_data),
      .q_ready  (queue_ready)
   );

   hamenc_fifo #(
      .Depth (QueueDepth)
   ) u_fifo (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (front_push),
      .wr_data  (front_data),
      .wr_ready (queue_ready),
      .rd_valid (queue_valid),
      .rd_data  (queue_data),
      .rd_en    (queue_pop)
   );

   // The back encodes one group per cycle, when the sink keeps up, straight into the output register,
   // so a finished word can wait for the sink while the next is in the queue.
   hamenc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (queue_valid),
      .q_data    (queue_data),
      .q_pop     (queue_pop),
      .out_valid (rsp_ch.valid),
      .out_ready (rsp_ch.ready),
      .out_word  (rsp_ch.codeword),
      .out_last  (rsp_ch.last_word)
   );

endmodule

`default_nettype wire

// ===== tb/hamenc_codeword_checker.sv =====
// Watches both channels of the byte stream SECDED(16,11) encoder, predicts the codewords
// of every accepted byte and compares them in order. Depends on nothing but its ports.
`default_nettype none

module hamenc_codeword_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_ready,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_last_byte,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_ready,
   input  wire logic [15:0] rsp_codeword,
   input  wire logic        rsp_last_word,
   output int               error_count,
   output int               words_due
);

   typedef struct packed {
      logic [15:0] codeword;
      logic        last_word;
   } coded_word_type;

   coded_word_type expected_words[$];

   // Predicted stream state.
   logic [10:0] pend_bits;
   int          pend_cnt;
   logic        odd_bytes;

   // Data fills the positions that are not powers of two, in rising order, from group
   // bit 10 down to bit 0. Position p is codeword bit 15-p.
   function automatic logic [15:0] secded_encode(input logic [10:0] grp);
      logic [15:0] cw;
      logic        par;
      int          idx;
      cw  = '0;
      idx = 10;
      for (int p = 1; p < 16; p++) begin
         if ((p & (p - 1)) != 0) begin
            cw[15-p] = grp[idx];
            idx--;
         end
      end
      for (int k = 0; k < 4; k++) begin
         par = 1'b0;
         for (int p = 1; p < 16; p++) begin
            if ((p & (1 << k)) != 0) par ^= cw[15-p];
         end
         cw[15-(1<<k)] = par;
      end
      cw[15] = ^cw[14:0];
      return cw;
   endfunction

   // Appends one byte to the pending bits; reports a completed group.
   task automatic take_byte(input logic [7:0] b, output bit full, output logic [10:0] grp);
      logic [18:0] acc;
      int          n;
      acc  = {pend_bits, b};
      n    = pend_cnt + 8;
      full = 1'b0;
      grp  = '0;
      if (n >= 11) begin
         n        = n - 11;
         grp      = 11'(acc >> n);
         pend_bits = acc[10:0] & 11'((1 << n) - 1);
         full     = 1'b1;
      end else begin
         pend_bits = acc[10:0];
      end
      pend_cnt = n;
   endtask

   task automatic predict_byte(input logic [7:0] b, input logic last);
      logic [15:0] words[3];
      logic [10:0] grp;
      bit          full;
      int          cnt;
      cnt       = 0;
      odd_bytes = ~odd_bytes;
      take_byte(b, full, grp);
      if (full) begin
         words[cnt] = secded_encode(grp);
         cnt++;
      end
      if (last) begin
         // An odd byte count gets one zero byte, then any partial group is zero filled.
         if (odd_bytes) begin
            take_byte(8'h00, full, grp);
            if (full) begin
               words[cnt] = secded_encode(grp);
               cnt++;
            end
         end
         if (pend_cnt != 0) begin
            words[cnt] = secded_encode(11'(pend_bits << (11 - pend_cnt)));
            cnt++;
         end
         pend_bits = '0;
         pend_cnt  = 0;
         odd_bytes = 1'b0;
      end
      for (int i = 0; i < cnt; i++) begin
         expected_words.push_back({words[i], last && (i == cnt - 1)});
      end
   endtask

   always @(posedge clock) begin
      coded_word_type want;
      if (reset) begin
         expected_words.delete();
         pend_bits = '0;
         pend_cnt  = 0;
         odd_bytes = 1'b0;
      end else begin
         if (req_valid && req_ready) predict_byte(req_data_byte, req_last_byte);
         if (rsp_valid && rsp_ready) begin
            if (expected_words.size() == 0) begin
               if (error_count < 10)
                  $display("%0t: unexpected word %h last %b", $realtime, rsp_codeword,
                           rsp_last_word);
               error_count++;
            end else begin
               want = expected_words.pop_front();
               if (rsp_codeword !== want.codeword) begin
                  if (error_count < 10)
                     $display("%0t: codeword expected %h actual %h", $realtime,
                              want.codeword, rsp_codeword);
                  error_count++;
               end
               if (rsp_last_word !== want.last_word) begin
                  if (error_count < 10)
                     $display("%0t: last_word expected %b actual %b", $realtime,
                              want.last_word, rsp_last_word);
                  error_count++;
               end
            end
         end
      end
      words_due = expected_words.size();
   end

endmodule

`default_nettype wire

// ===== tb/byte_stream_hamming_16_11_encoder_core_test.sv =====
// Top of the encoder testbench: clock, reset, byte stream stimulus and result back pressure.
// Depends on the encoder RTL, its interfaces and hamenc_codeword_checker.
`default_nettype none

module byte_stream_hamming_16_11_encoder_core_test;

   // This limit only catches a hung block; a clean run ends well before it.
   localparam int CycleLimit = 200000;
   localparam int RandomBytes = 460;
   localparam int IdlePercent = 29;
   // Byte counts between these two see no idling on either side.
   localparam int CalmFrom = 150;
   localparam int CalmTo   = 250;
   // Once this many bytes have gone in, the receiver holds off for a long stretch.
   localparam int HoldAt     = 300;
   localparam int HoldCycles = 80;

   logic clock;
   logic reset;
   int   cycles;
   int   bytes_sent;
   int   error_count;
   int   words_due;

   hamenc_req_if req_if ();
   hamenc_rsp_if rsp_if ();

   byte_stream_hamming_16_11_encoder_core u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if)
   );

   hamenc_codeword_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_if.valid),
      .req_ready     (req_if.ready),
      .req_data_byte (req_if.data_byte),
      .req_last_byte (req_if.last_byte),
      .rsp_valid     (rsp_if.valid),
      .rsp_ready     (rsp_if.ready),
      .rsp_codeword  (rsp_if.codeword),
      .rsp_last_word (rsp_if.last_word),
      .error_count   (error_count),
      .words_due     (words_due)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Watchdog. A run that gets here never finished its stimulus or never drained.
   initial cycles = 0;
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CycleLimit) begin
         $display("byte_stream_hamming_16_11_encoder_core_test: done, errors");
         $finish;
      end
   end

   function automatic bit calm();
      return bytes_sent >= CalmFrom && bytes_sent < CalmTo;
   endfunction

   // Result side back pressure. Ready is random most of the time, steady high in the calm
   // stretch, and low for one long stretch so that the queue inside the block fills up
   // and the input side stalls while the sender keeps offering bytes.
   initial begin
      int hold_left;
      bit hold_done;
      hold_left = 0;
      hold_done = 1'b0;
      rsp_if.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!hold_done && bytes_sent >= HoldAt) begin
            hold_done = 1'b1;
            hold_left = HoldCycles;
         end
         if (reset) begin
            rsp_if.ready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else if (calm()) begin
            rsp_if.ready <= 1'b1;
         end else begin
            rsp_if.ready <= ($urandom_range(0, 99) >= IdlePercent);
         end
      end
   end

   // Offers one byte, called right at a rising edge. Random idle cycles come first; then
   // valid is held until the edge at which ready was high, which is the accepting edge.
   // The next call drives its byte in that same step, so valid drops in between only when it draws idle cycles.
   task automatic put_byte(input logic [7:0] b, input logic last);
      while (!calm() && $urandom_range(0, 99) < IdlePercent) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.data_byte <= b;
      req_if.last_byte <= last;
      do @(posedge clock); while (!req_if.ready);
      bytes_sent++;
   endtask

   // Mostly random bytes, with all-zero and all-one bytes frequent.
   function automatic logic [7:0] pick_byte();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 15) return 8'h00;
      if (roll < 30) return 8'hFF;
      return 8'($urandom);
   endfunction

   // Stream lengths: mostly short, some medium ones, some that end exactly on a group
   // boundary (21 bytes plus the pad byte, or 22 bytes), and a few long ones.
   function automatic int pick_length();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return $urandom_range(1, 8);
      if (roll < 85) return $urandom_range(9, 30);
      if (roll < 95) return $urandom_range(21, 22);
      return $urandom_range(40, 60);
   endfunction

   initial begin
      int len;
      bytes_sent       = 0;
      reset            = 1'b1;
      req_if.valid     = 1'b0;
      req_if.data_byte = 8'h00;
      req_if.last_byte = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // A single byte stream, all zeros and all ones: the pad byte makes 16 bits, which is
      // one full group plus a five bit flush.
      put_byte(8'h00, 1'b1);
      put_byte(8'hFF, 1'b1);
      // An even stream: no pad byte, one group and a flush.
      put_byte(8'hAA, 1'b0);
      put_byte(8'h55, 1'b1);
      // Five bytes: the final byte completes a group, the pad byte completes another, and
      // four bits remain for the flush, so the final byte yields three words.
      put_byte(8'hFF, 1'b0);
      put_byte(8'h00, 1'b0);
      put_byte(8'h80, 1'b0);
      put_byte(8'h01, 1'b0);
      put_byte(8'hFF, 1'b1);
      // Same shape with all ones, so every data bit is set in the first three words.
      repeat (4) put_byte(8'hFF, 1'b0);
      put_byte(8'hFF, 1'b1);

      // Random streams. Every stream ends with a marked final byte.
      while (bytes_sent < RandomBytes) begin
         len = pick_length();
         for (int i = 0; i < len; i++) put_byte(pick_byte(), i == len - 1);
      end
      req_if.valid     <= 1'b0;
      req_if.last_byte <= 1'b0;

      // Drain, then keep watching the result channel for any stray word.
      while (words_due != 0) @(posedge clock);
      repeat (12) @(posedge clock);
      if (error_count == 0 && words_due == 0) begin
         $display("byte_stream_hamming_16_11_encoder_core_test: done, clean");
      end else begin
         $display("byte_stream_hamming_16_11_encoder_core_test: done, errors");
      end
      $finish;
   end

endmodule

`default_nettype wire
